// ===== design/owsl_pkg.sv =====
// ----------------------------------------------------------------------------
// owsl_pkg
// Shared constants, register codes and pipeline flag type for the omni wheel
// speed limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package owsl_pkg;

  localparam int VEL_WIDTH_DEF  = 16;
  localparam int LIMIT_WIDTH    = 15;
  localparam int RADIUS_WIDTH   = 16;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int WHEEL_WIDTH    = 16;
  localparam int CONST_WIDTH    = 16;

  // Q.16 wheel sums; half of vx is a shift by 15, Q8.8 radius product by 8
  localparam int FRAC_BITS    = 16;
  localparam int HALF_SHIFT   = 15;
  localparam int RADIUS_SHIFT = 8;
  // magnitude bits of a wheel sum above the velocity width
  localparam int HEAD_BITS    = 24;

  // input reg, multiply, sum, abs, max, limit compare
  localparam int FRONT_STAGES = 6;

  localparam logic [LIMIT_WIDTH-1:0]  LIMIT_RESET    = 15'd8500;
  localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET   = 16'd256;
  localparam logic [CONST_WIDTH-1:0]  SQRT3_HALF_Q16 = 16'd56756;

  typedef enum logic {
    CFG_MAX_SPEED = 1'b0,
    CFG_RADIUS    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic       scaled;
    logic [2:0] neg;
  } owsl_flags_t;

endpackage

`default_nettype wire

// ===== design/owsl_div_step.sv =====
// ----------------------------------------------------------------------------
// owsl_div_step
// One registered step of the scaling divider, three lanes: folds in one
// limit bit and produces one radix-2 quotient digit (0..2) per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module owsl_div_step #(
  parameter int MW = owsl_pkg::VEL_WIDTH_DEF + owsl_pkg::HEAD_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic                                    lim_bit_i,
  input  logic [MW-1:0]                           divisor_i,
  input  logic [2:0][MW-1:0]                      mag_i,
  input  logic [2:0][MW-1:0]                      rem_i,
  input  logic [2:0][owsl_pkg::LIMIT_WIDTH-1:0]   quo_i,
  input  owsl_pkg::owsl_flags_t                   flags_i,
  output logic [MW-1:0]                           divisor_o,
  output logic [2:0][MW-1:0]                      mag_o,
  output logic [2:0][MW-1:0]                      rem_o,
  output logic [2:0][owsl_pkg::LIMIT_WIDTH-1:0]   quo_o,
  output owsl_pkg::owsl_flags_t                   flags_o
);

  import owsl_pkg::*;

  localparam int TW = MW + 2;

  logic [TW-1:0]                   c1;
  logic [TW-1:0]                   c2;
  logic [2:0][TW-1:0]              t;
  logic [2:0][TW-1:0]              rt;
  logic [2:0][1:0]                 dig;
  logic [2:0][MW-1:0]              rem_d;
  logic [2:0][LIMIT_WIDTH-1:0]     quo_d;

  always_comb begin
    c1 = {2'b00, divisor_i};
    c2 = {1'b0, divisor_i, 1'b0};
    for (int i = 0; i < 3; i++) begin
      t[i] = {1'b0, rem_i[i], 1'b0} + (lim_bit_i ? {2'b00, mag_i[i]} : {TW{1'b0}});
      if (t[i] >= c2) begin
        rt[i]  = t[i] - c2;
        dig[i] = 2'd2;
      end else if (t[i] >= c1) begin
        rt[i]  = t[i] - c1;
        dig[i] = 2'd1;
      end else begin
        rt[i]  = t[i];
        dig[i] = 2'd0;
      end
      rem_d[i] = rt[i][MW-1:0];
      quo_d[i] = {quo_i[i][LIMIT_WIDTH-2:0], 1'b0} + LIMIT_WIDTH'(dig[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      divisor_o <= divisor_i;
      mag_o     <= mag_i;
      rem_o     <= rem_d;
      quo_o     <= quo_d;
      flags_o   <= flags_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/omni_wheel_speed_limiter.sv =====
// Throughput: one word per cycle; each pipeline stage holds one word and
// stalls only when it is full and the stage ahead of it cannot take its word.
// Scaling divider: 15 pipelined steps, one limit bit per step.
// Reset: pipeline emptied, limit = 8500, radius = 1.0 (Q8.8).
// ----------------------------------------------------------------------------
// omni_wheel_speed_limiter
// Three-wheel omni inverse kinematics in Q.16 fixed point, with proportional
// scaling of all wheels when the largest wheel speed exceeds the limit.
// ----------------------------------------------------------------------------
`default_nettype none

module omni_wheel_speed_limiter #(
  parameter int VEL_WIDTH = owsl_pkg::VEL_WIDTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic signed [VEL_WIDTH-1:0]                vel_x_i,
  input  logic signed [VEL_WIDTH-1:0]                vel_y_i,
  input  logic signed [VEL_WIDTH-1:0]                turn_rate_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic signed [owsl_pkg::WHEEL_WIDTH-1:0]    wheel_one_o,
  output logic signed [owsl_pkg::WHEEL_WIDTH-1:0]    wheel_two_o,
  output logic signed [owsl_pkg::WHEEL_WIDTH-1:0]    wheel_three_o,
  output logic                                       was_scaled_o,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  owsl_pkg::cfg_idx_e                         cfg_idx_i,
  input  logic [owsl_pkg::CFG_DATA_WIDTH-1:0]        cfg_data_i
);

  import owsl_pkg::*;

  localparam int MW  = VEL_WIDTH + HEAD_BITS;
  localparam int QW  = MW + 1;
  localparam int PW  = VEL_WIDTH + CONST_WIDTH + 1;
  localparam int NST = FRONT_STAGES + LIMIT_WIDTH + 1;

  // configuration
  logic [LIMIT_WIDTH-1:0]  limit_q;
  logic [RADIUS_WIDTH-1:0] radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      radius_q <= RADIUS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        CFG_MAX_SPEED: limit_q  <= cfg_data_i[LIMIT_WIDTH-1:0];
        CFG_RADIUS:    radius_q <= cfg_data_i[RADIUS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage load enables
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end
  assign en[NST-1] = ~v_q[NST-1] | out_ready_i;

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 0: input register
  logic signed [VEL_WIDTH-1:0] x0_q, y0_q, w0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x0_q <= vel_x_i;
      y0_q <= vel_y_i;
      w0_q <= turn_rate_i;
    end
  end

  // stage 1: radius and sqrt3/2 products
  logic signed [PW-1:0]        rw1_d, sy1_d, rw1_q, sy1_q;
  logic signed [VEL_WIDTH-1:0] x1_q;

  assign rw1_d = $signed({1'b0, radius_q}) * w0_q;
  assign sy1_d = $signed({1'b0, SQRT3_HALF_Q16}) * y0_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      rw1_q <= rw1_d;
      sy1_q <= sy1_d;
      x1_q  <= x0_q;
    end
  end

  // stage 2: Q.16 wheel sums
  logic signed [QW-1:0] xf, xh, sy_e, rw_e;
  logic signed [QW-1:0] q2_d [3];
  logic signed [QW-1:0] q2_q [3];

  always_comb begin
    xf      = QW'(x1_q) <<< FRAC_BITS;
    xh      = QW'(x1_q) <<< HALF_SHIFT;
    sy_e    = QW'(sy1_q);
    rw_e    = QW'(rw1_q) <<< RADIUS_SHIFT;
    q2_d[0] = -xf - rw_e;
    q2_d[1] = xh + sy_e - rw_e;
    q2_d[2] = xh - sy_e - rw_e;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      q2_q <= q2_d;
    end
  end

  // stage 3: magnitude and sign
  logic [2:0][MW-1:0] mag3_d, mag3_q;
  logic [2:0]         neg3_q;
  logic [QW-1:0]      abs3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs3[i]   = q2_q[i][QW-1] ? -q2_q[i] : q2_q[i];
      mag3_d[i] = abs3[i][MW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      mag3_q <= mag3_d;
      for (int i = 0; i < 3; i++) begin
        neg3_q[i] <= q2_q[i][QW-1];
      end
    end
  end

  // stage 4: largest magnitude
  logic [MW-1:0]      m01, max4_d, max4_q;
  logic [2:0][MW-1:0] mag4_q;
  logic [2:0]         neg4_q;

  always_comb begin
    m01    = (mag3_q[0] >= mag3_q[1]) ? mag3_q[0] : mag3_q[1];
    max4_d = (m01 >= mag3_q[2]) ? m01 : mag3_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      max4_q <= max4_d;
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
    end
  end

  // stage 5: limit compare
  logic [MW-1:0]      lim_q16;
  logic [MW-1:0]      max5_q;
  logic [2:0][MW-1:0] mag5_q;
  owsl_flags_t        flags5_q;

  assign lim_q16 = MW'({limit_q, {FRAC_BITS{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      max5_q          <= max4_q;
      mag5_q          <= mag4_q;
      flags5_q.scaled <= (max4_q > lim_q16);
      flags5_q.neg    <= neg4_q;
    end
  end

  // scaling divider: floor(mag * limit / max), one limit bit per step
  logic [MW-1:0]                   dv_max   [LIMIT_WIDTH+1];
  logic [2:0][MW-1:0]              dv_mag   [LIMIT_WIDTH+1];
  logic [2:0][MW-1:0]              dv_rem   [LIMIT_WIDTH+1];
  logic [2:0][LIMIT_WIDTH-1:0]     dv_quo   [LIMIT_WIDTH+1];
  owsl_flags_t                     dv_flags [LIMIT_WIDTH+1];

  assign dv_max[0]   = max5_q;
  assign dv_mag[0]   = mag5_q;
  assign dv_rem[0]   = '0;
  assign dv_quo[0]   = '0;
  assign dv_flags[0] = flags5_q;

  for (genvar k = 0; k < LIMIT_WIDTH; k++) begin : g_div
    owsl_div_step #(
      .MW(MW)
    ) u_step (
      .clk_i     (clk_i),
      .en_i      (en[FRONT_STAGES+k]),
      .lim_bit_i (limit_q[LIMIT_WIDTH-1-k]),
      .divisor_i (dv_max[k]),
      .mag_i     (dv_mag[k]),
      .rem_i     (dv_rem[k]),
      .quo_i     (dv_quo[k]),
      .flags_i   (dv_flags[k]),
      .divisor_o (dv_max[k+1]),
      .mag_o     (dv_mag[k+1]),
      .rem_o     (dv_rem[k+1]),
      .quo_o     (dv_quo[k+1]),
      .flags_o   (dv_flags[k+1])
    );
  end

  // output stage: pick scaled or truncated magnitude, restore sign
  logic [2:0][LIMIT_WIDTH-1:0] res_mag;
  logic [2:0][WHEEL_WIDTH-1:0] res_d;
  owsl_flags_t                 fl_last;

  assign fl_last = dv_flags[LIMIT_WIDTH];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_mag[i] = fl_last.scaled ? dv_quo[LIMIT_WIDTH][i]
                                  : dv_mag[LIMIT_WIDTH][i][FRAC_BITS +: LIMIT_WIDTH];
      res_d[i]   = fl_last.neg[i] ? -WHEEL_WIDTH'(res_mag[i]) : WHEEL_WIDTH'(res_mag[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      wheel_one_o   <= res_d[0];
      wheel_two_o   <= res_d[1];
      wheel_three_o <= res_d[2];
      was_scaled_o  <= fl_last.scaled;
    end
  end

  // checks
  logic [WHEEL_WIDTH-1:0] chk_a1, chk_a2, chk_a3, chk_lim;

  assign chk_a1  = wheel_one_o[WHEEL_WIDTH-1]   ? -wheel_one_o   : wheel_one_o;
  assign chk_a2  = wheel_two_o[WHEEL_WIDTH-1]   ? -wheel_two_o   : wheel_two_o;
  assign chk_a3  = wheel_three_o[WHEEL_WIDTH-1] ? -wheel_three_o : wheel_three_o;
  assign chk_lim = WHEEL_WIDTH'(limit_q);

  a_out_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (chk_a1 <= chk_lim) && (chk_a2 <= chk_lim) && (chk_a3 <= chk_lim))
    else $error("wheel speed above limit");

  a_scaled_nonzero_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[FRONT_STAGES-1] && flags5_q.scaled) |-> (max5_q != '0))
    else $error("scaling with zero divisor");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted word lost at input stage");

endmodule

`default_nettype wire
